// File: rtl/s2a_pkg.sv
// Shared types, constants and the scancode translation table for the scancode-to-ASCII FIFO.
package s2a_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam int unsigned CODE_W           = 8;
  localparam int unsigned CHAR_W           = 7;
  localparam int unsigned RELEASE_BIT      = 7;  // set-1 break code flag (0x80)

  typedef enum logic {
    OP_SCANCODE = 1'b0,
    OP_READ     = 1'b1
  } op_e;

  // decoded view of one input item
  typedef struct packed {
    logic              push;      // mapped character to echo and buffer
    logic              pop;       // read request
    logic [CHAR_W-1:0] char_val;  // mapped character, zero when push is low
  } dec_t;

  // result fields that are settled when the item is accepted
  typedef struct packed {
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              dropped;
    logic              read_valid;
    logic              not_empty;
  } res_t;

  // set-1 make code (low 7 bits) to ASCII; zero means unmapped
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      7'd1:    c = 7'h1B;
      7'd2:    c = 7'h31;
      7'd3:    c = 7'h32;
      7'd4:    c = 7'h33;
      7'd5:    c = 7'h34;
      7'd6:    c = 7'h35;
      7'd7:    c = 7'h36;
      7'd8:    c = 7'h37;
      7'd9:    c = 7'h38;
      7'd10:   c = 7'h39;
      7'd11:   c = 7'h30;
      7'd12:   c = 7'h2D;
      7'd13:   c = 7'h3D;
      7'd14:   c = 7'h08;
      7'd15:   c = 7'h09;
      7'd16:   c = 7'h71;
      7'd17:   c = 7'h77;
      7'd18:   c = 7'h65;
      7'd19:   c = 7'h72;
      7'd20:   c = 7'h74;
      7'd21:   c = 7'h79;
      7'd22:   c = 7'h75;
      7'd23:   c = 7'h69;
      7'd24:   c = 7'h6F;
      7'd25:   c = 7'h70;
      7'd26:   c = 7'h5B;
      7'd27:   c = 7'h5D;
      7'd28:   c = 7'h0A;
      7'd30:   c = 7'h61;
      7'd31:   c = 7'h73;
      7'd32:   c = 7'h64;
      7'd33:   c = 7'h66;
      7'd34:   c = 7'h67;
      7'd35:   c = 7'h68;
      7'd36:   c = 7'h6A;
      7'd37:   c = 7'h6B;
      7'd38:   c = 7'h6C;
      7'd39:   c = 7'h3B;
      7'd40:   c = 7'h27;
      7'd41:   c = 7'h60;
      7'd43:   c = 7'h5C;
      7'd44:   c = 7'h7A;
      7'd45:   c = 7'h78;
      7'd46:   c = 7'h63;
      7'd47:   c = 7'h76;
      7'd48:   c = 7'h62;
      7'd49:   c = 7'h6E;
      7'd50:   c = 7'h6D;
      7'd51:   c = 7'h2C;
      7'd52:   c = 7'h2E;
      7'd53:   c = 7'h2F;
      7'd55:   c = 7'h2A;
      7'd57:   c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/s2a_if.sv
// Valid/ready channel interfaces for the scancode-to-ASCII FIFO input and result items.
interface s2a_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] scancode;

  modport source (output valid, output operation, output scancode, input ready);
  modport sink   (input valid, input operation, input scancode, output ready);
endinterface

interface s2a_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [6:0] echo_char;
  logic       dropped;
  logic       read_valid;
  logic [6:0] read_char;
  logic       not_empty;

  modport source (output valid, output echo_valid, output echo_char, output dropped,
                  output read_valid, output read_char, output not_empty, input ready);
  modport sink   (input valid, input echo_valid, input echo_char, input dropped,
                  input read_valid, input read_char, input not_empty, output ready);
endinterface

// File: rtl/s2a_ram.sv
// Generic single-clock RAM, one write and one read port, registered read data.
module s2a_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/s2a_dec.sv
// Input item decoder: drops break codes, translates make codes, flags reads.
module s2a_dec (
  input  logic                      operation_i,
  input  logic [s2a_pkg::CODE_W-1:0] scancode_i,
  output s2a_pkg::dec_t             dec_o
);
  import s2a_pkg::*;

  logic [CHAR_W-1:0] mapped;
  logic              is_code;

  always_comb begin
    mapped         = ascii_of(scancode_i[CHAR_W-1:0]);
    is_code        = (op_e'(operation_i) == OP_SCANCODE) && !scancode_i[RELEASE_BIT];
    dec_o.pop      = (op_e'(operation_i) == OP_READ);
    dec_o.push     = is_code && (mapped != '0);
    dec_o.char_val = dec_o.push ? mapped : '0;
  end

endmodule

// File: rtl/scancode_to_ascii_fifo_unit.sv
// Top level: set-1 scancode translator feeding a character ring buffer in RAM.
//
// Input channel in_i carries one item per handshake: operation 0 with a
// scancode byte, or operation 1 to read the oldest buffered character.
// Output channel out_o returns exactly one result item per input item,
// in order. Break codes and unmapped codes give an all-zero result apart
// from not_empty; a mapped character is echoed and, if there is room,
// written to the ring buffer (BUFFER_DEPTH-1 usable slots), else flagged
// as dropped. A read on an empty buffer returns read_valid low.
//
// The item is decoded and the pointers updated at acceptance while the
// RAM is written or read, and its result waits in the middle stage; once
// the output register is free or being taken, the registered RAM data
// joins the result there. Throughput: one item per cycle, held only by
// the output register when the receiver stalls; a stalled result keeps
// one item waiting behind it and input ready then drops.
//
// Reset clears both pointers and the valid flags; buffer contents are not
// cleared, since only written slots are ever read.
module scancode_to_ascii_fifo_unit #(
  parameter int unsigned BUFFER_DEPTH = s2a_pkg::BUFFER_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  s2a_in_if.sink   in_i,
  s2a_out_if.source out_o
);
  import s2a_pkg::*;

  localparam int unsigned PtrW = $clog2(BUFFER_DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(BUFFER_DEPTH - 1);

  dec_t dec;

  // ring pointers
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW-1:0] wr_nxt, rd_nxt;
  logic            full, empty;

  // middle stage: result waiting for RAM read data
  logic pend_q, pend_d;
  res_t pend_res_q, pend_res_d;

  // output register
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q, out_res_d;
  logic [CHAR_W-1:0] out_rchar_q, out_rchar_d;

  logic              acc, pend_move, do_push, do_pop;
  logic [CHAR_W-1:0] rdata;

  s2a_dec u_dec (
    .operation_i (in_i.operation),
    .scancode_i  (in_i.scancode),
    .dec_o       (dec)
  );

  // the middle stage advances whenever the output register is free or being taken
  assign pend_move = pend_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_q || pend_move;
  assign acc       = in_i.valid && in_i.ready;

  assign wr_nxt  = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
  assign rd_nxt  = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
  assign full    = (wr_nxt == rd_q);
  assign empty   = (wr_q == rd_q);
  assign do_push = acc && dec.push && !full;
  assign do_pop  = acc && dec.pop && !empty;

  s2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_q),
    .wdata_i (dec.char_val),
    .re_i    (do_pop),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  always_comb begin
    wr_d        = do_push ? wr_nxt : wr_q;
    rd_d        = do_pop ? rd_nxt : rd_q;

    pend_d      = acc || (pend_q && !pend_move);
    pend_res_d  = pend_res_q;
    if (acc) begin
      pend_res_d.echo_valid = dec.push;
      pend_res_d.echo_char  = dec.char_val;
      pend_res_d.dropped    = dec.push && full;
      pend_res_d.read_valid = do_pop;
      pend_res_d.not_empty  = (wr_d != rd_d);
    end

    out_valid_d = pend_move || (out_valid_q && !out_o.ready);
    out_res_d   = out_res_q;
    out_rchar_d = out_rchar_q;
    if (pend_move) begin
      out_res_d   = pend_res_q;
      out_rchar_d = pend_res_q.read_valid ? rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_res_q  <= pend_res_d;
    out_res_q   <= out_res_d;
    out_rchar_q <= out_rchar_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.echo_valid = out_res_q.echo_valid;
  assign out_o.echo_char  = out_res_q.echo_char;
  assign out_o.dropped    = out_res_q.dropped;
  assign out_o.read_valid = out_res_q.read_valid;
  assign out_o.read_char  = out_rchar_q;
  assign out_o.not_empty  = out_res_q.not_empty;

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q <= LastIdx) && (rd_q <= LastIdx))
    else $error("ring pointer out of range");

  // a stored push leaves the buffer non-empty
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> (wr_q != rd_q))
    else $error("push left buffer empty");

  // a stalled pending item is not lost
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_valid_q && !out_o.ready) |=> (pend_q && $stable(pend_res_q)))
    else $error("pending item lost under stall");

  // a dropped flag only ever comes with an echo, and never with a read
  a_drop_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.dropped |-> out_res_q.echo_valid && !out_res_q.read_valid)
    else $error("dropped without echo");

  // read and write pointers never move in the same cycle
  a_one_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_push && do_pop))
    else $error("push and pop together");

endmodule
